FILE: src/frss_pkg.sv
// shared types, constants and segment encoding for the frame rate display block
package frss_pkg;

  localparam int TPS_W = 27;
  localparam int NUM_W = 34;
  localparam int TIME_W = 32;
  localparam int VAL_W = 16;
  localparam int NHI_W = NUM_W - VAL_W;
  localparam int BCD_W = 20;

  localparam logic [NUM_W-1:0] TPS_SCALE = 34'd100;
  localparam logic [NUM_W-1:0] TPS_X100_RESET = 34'd100000000;
  localparam logic [VAL_W-1:0] FPS_MAX = 16'hFFFF;
  localparam logic [7:0] SEG_DP = 8'h80;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } in_word_t;

  typedef struct packed {
    logic [23:0] low_digits_word;
    logic [7:0]  high_digit_byte;
    logic        overflow;
  } out_word_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic [NHI_W-1:0]  n_high;
    logic [VAL_W-1:0]  n_low;
    logic              ovf;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_BCD  = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

  // active-low segments a..g, decimal point off
  function automatic logic [7:0] digit_code(input logic [3:0] d);
    logic [6:0] seg;
    begin
      case (d)
        4'd0: seg = 7'h3F;
        4'd1: seg = 7'h06;
        4'd2: seg = 7'h5B;
        4'd3: seg = 7'h4F;
        4'd4: seg = 7'h66;
        4'd5: seg = 7'h6D;
        4'd6: seg = 7'h7D;
        4'd7: seg = 7'h07;
        4'd8: seg = 7'h7F;
        4'd9: seg = 7'h6F;
        default: seg = 7'h3F;
      endcase
      digit_code = {1'b0, ~seg} | SEG_DP;
    end
  endfunction

endpackage

FILE: src/frss_front.sv
// front end: holds the scaled tick rate, forms elapsed time and flags saturation
module frss_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [frss_pkg::TPS_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  frss_pkg::in_word_t              in_word,
  input  logic                            q_full,
  output logic                            push,
  output frss_pkg::job_t                  push_item
);

  logic [frss_pkg::NUM_W-1:0]  tps_x100;
  logic [frss_pkg::TIME_W-1:0] elapsed;
  logic [frss_pkg::NHI_W-1:0]  n_high;

  // numerator kept premultiplied by 100
  always_ff @(posedge clk) begin
    if (rst) begin
      tps_x100 <= frss_pkg::TPS_X100_RESET;
    end else if (cfg_we) begin
      tps_x100 <= frss_pkg::NUM_W'(cfg_data) * frss_pkg::TPS_SCALE;
    end
  end

  assign elapsed = in_word.end_time - in_word.start_time;
  assign n_high  = tps_x100[frss_pkg::NUM_W-1:frss_pkg::VAL_W];

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // quotient exceeds 16 bits exactly when the upper numerator reaches elapsed
  always_comb begin
    push_item.elapsed = elapsed;
    push_item.n_high  = n_high;
    push_item.n_low   = tps_x100[frss_pkg::VAL_W-1:0];
    push_item.ovf     = (frss_pkg::TIME_W'(n_high) >= elapsed);
  end

endmodule

FILE: src/frss_queue.sv
// two-entry queue decoupling the front end from the back end
module frss_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  frss_pkg::job_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output frss_pkg::job_t head
);

  frss_pkg::job_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/frss_back.sv
// back end: serial divider, serial binary-to-bcd and segment encoder with output register
module frss_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_avail,
  input  frss_pkg::job_t       q_head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output frss_pkg::out_word_t  out_word
);

  frss_pkg::back_state_t          state;
  logic [3:0]                     cnt;
  logic [frss_pkg::TIME_W-1:0]    divisor;
  logic [frss_pkg::TIME_W-1:0]    rem;
  logic [frss_pkg::VAL_W-1:0]     quo;
  logic                           ovf;
  logic [frss_pkg::VAL_W-1:0]     bin;
  logic [frss_pkg::BCD_W-1:0]     bcd;

  logic [frss_pkg::TIME_W:0]      trial;
  logic [frss_pkg::TIME_W:0]      diff;
  logic                           ge;
  logic [frss_pkg::BCD_W-1:0]     bcd_adj;
  logic                           slot_free;
  logic [7:0]                     code0;
  logic [7:0]                     code1;
  logic [7:0]                     code2;
  logic [7:0]                     code3;

  assign pop       = (state == frss_pkg::ST_IDLE) && q_avail;
  assign slot_free = !out_valid || !out_stall;

  // restoring division step
  always_comb begin
    trial = {rem, quo[frss_pkg::VAL_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // add 3 to each digit of 5 or more before shifting
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    code0 = frss_pkg::digit_code(bcd[3:0]);
    code1 = frss_pkg::digit_code(bcd[7:4]);
    code2 = frss_pkg::digit_code(bcd[11:8]) & 8'h7F;
    code3 = frss_pkg::digit_code(bcd[15:12]);
  end

  always_ff @(posedge clk) begin
    case (state)
      frss_pkg::ST_IDLE: begin
        if (q_avail) begin
          divisor <= q_head.elapsed;
          rem     <= q_head.ovf ? '0 : frss_pkg::TIME_W'(q_head.n_high);
          quo     <= q_head.n_low;
          ovf     <= q_head.ovf;
        end
      end
      frss_pkg::ST_DIV: begin
        rem <= ge ? diff[frss_pkg::TIME_W-1:0] : trial[frss_pkg::TIME_W-1:0];
        quo <= {quo[frss_pkg::VAL_W-2:0], ge};
        if (cnt == 4'd15) begin
          bin <= ovf ? frss_pkg::FPS_MAX : {quo[frss_pkg::VAL_W-2:0], ge};
          bcd <= '0;
        end
      end
      frss_pkg::ST_BCD: begin
        {bcd, bin} <= {bcd_adj[frss_pkg::BCD_W-2:0], bin, 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == frss_pkg::ST_DONE && slot_free) begin
      out_word <= {code2, code1, code0, code3, ovf};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= frss_pkg::ST_IDLE;
      cnt       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (state == frss_pkg::ST_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        frss_pkg::ST_IDLE: begin
          cnt <= 4'd0;
          if (q_avail) begin
            state <= frss_pkg::ST_DIV;
          end
        end
        frss_pkg::ST_DIV: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= frss_pkg::ST_BCD;
          end
        end
        frss_pkg::ST_BCD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= frss_pkg::ST_DONE;
          end
        end
        frss_pkg::ST_DONE: begin
          if (slot_free) begin
            state <= frss_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= frss_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/frame_rate_seven_segment.sv
// top level of the frame rate to seven-segment display encoder
// usage:
//   input channel in_valid/in_stall/in_word: one word per frame carrying the
//   start and end timer readings; a word is taken when in_valid is high and
//   in_stall is low
//   output channel out_valid/out_stall/out_word: one word per input word with
//   three packed segment codes, the tens digit code and the overflow flag
//   cfg_we/cfg_data: writes ticks_per_second; the user must write it only
//   while the block is idle, the block itself does not enforce this
// sequence:
//   the back end loads an item from the queue, then runs a serial restoring
//   divider and a serial binary-to-bcd converter, then unloads the result to
//   the output register; it takes the next item only when done with the last
//   a two-entry queue lets the front keep taking words while the back works
// reset (rst, synchronous): queue and output empty, ticks_per_second 1000000
// a stalled receiver holds the output word; the back end finishes its item
// and waits, then the queue fills and in_stall rises
module frame_rate_seven_segment (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [frss_pkg::TPS_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  frss_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output frss_pkg::out_word_t         out_word
);

  // front to queue
  logic           push;
  frss_pkg::job_t push_item;
  logic           q_full;

  // queue to back
  logic           pop;
  logic           q_avail;
  frss_pkg::job_t q_head;

  // elapsed time, saturation check, scaled numerator register
  frss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  frss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  // divide, convert to digits, encode segments
  frss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
